FILE: design/acrb_pkg.sv
// ============================================================================
// acrb_pkg
// Shared types and constants for the audio capture ring buffer.
// ============================================================================
package acrb_pkg;

    localparam int STORE_WORDS  = 65536;
    localparam int STORE_AW     = $clog2(STORE_WORDS);
    localparam int MAX_CHANNELS = 32;
    localparam int CH_W         = $clog2(MAX_CHANNELS);
    localparam int SAMPLE_BITS  = 24;
    localparam int PEAK_W       = SAMPLE_BITS - 1;
    localparam int FRAME_W      = 16;
    localparam int RING_W       = 17;
    localparam int NCH_W        = 6;
    localparam int CNT_W        = 32;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CHANNELS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_FRAMES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RECORD_ENABLE = 2'd2;

    localparam logic [1:0] REQ_HEADER  = 2'd0;
    localparam logic [1:0] REQ_SAMPLE  = 2'd1;
    localparam logic [1:0] REQ_READ    = 2'd2;
    localparam logic [1:0] REQ_RESTART = 2'd3;

    localparam logic [PEAK_W-1:0]      PEAK_MAX     = {PEAK_W{1'b1}};
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MOST_NEG = {1'b1, {PEAK_W{1'b0}}};
    localparam logic [CNT_W-1:0]       CNT_MAX      = {CNT_W{1'b1}};

    localparam logic [NCH_W-1:0]  NCH_RESET  = 6'd2;
    localparam logic [RING_W-1:0] RING_RESET = 17'd32768;

    // frames that fit the store for 1..32 channels, indexed by channels - 1
    localparam logic [RING_W-1:0] RING_CAP [MAX_CHANNELS] = '{
        17'd65536, 17'd32768, 17'd21845, 17'd16384, 17'd13107, 17'd10922,
        17'd9362,  17'd8192,  17'd7281,  17'd6553,  17'd5957,  17'd5461,
        17'd5041,  17'd4681,  17'd4369,  17'd4096,  17'd3855,  17'd3640,
        17'd3449,  17'd3276,  17'd3120,  17'd2978,  17'd2849,  17'd2730,
        17'd2621,  17'd2520,  17'd2427,  17'd2340,  17'd2259,  17'd2184,
        17'd2114,  17'd2048
    };

    typedef struct packed {
        logic latch;
        logic calc_mod;
        logic calc_addr;
        logic mem_access;
        logic update;
        logic query;
        logic done;
    } ctrl_cmd_t;

    typedef struct packed {
        logic store_access;
    } dp_status_t;

endpackage

FILE: design/acrb_ram.sv
// ============================================================================
// acrb_ram
// Generic single write, single read RAM with registered read data.
// ============================================================================
module acrb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: design/acrb_ctrl.sv
// ============================================================================
// acrb_ctrl
// Sequencer: steps one request through address, memory, update and query.
// ============================================================================
module acrb_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  acrb_pkg::dp_status_t status,
    output logic                 busy,
    output acrb_pkg::ctrl_cmd_t  cmd
);

    import acrb_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MOD  = 3'd1;
    localparam logic [2:0] ST_ADDR = 3'd2;
    localparam logic [2:0] ST_MEM  = 3'd3;
    localparam logic [2:0] ST_UPD  = 3'd4;
    localparam logic [2:0] ST_QRY  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                cmd.calc_mod = 1'b1;
                // headers, restarts and empty reads never touch the store
                state_next   = status.store_access ? ST_ADDR : ST_UPD;
            end
            ST_ADDR:
            begin
                cmd.calc_addr = 1'b1;
                state_next    = ST_MEM;
            end
            ST_MEM:
            begin
                cmd.mem_access = 1'b1;
                state_next     = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.update = 1'b1;
                state_next = ST_QRY;
            end
            ST_QRY:
            begin
                cmd.query  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                cmd.done   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

FILE: design/acrb_dp.sv
// ============================================================================
// acrb_dp
// Datapath: configuration, ring positions, sample store, peak holds, counts.
// ============================================================================
module acrb_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  acrb_pkg::ctrl_cmd_t                 cmd,
    output acrb_pkg::dp_status_t                status,
    input  logic                                cfg_write,
    input  logic [acrb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [acrb_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [1:0]                          req_type,
    input  logic [acrb_pkg::FRAME_W-1:0]        block_frames,
    input  logic signed [acrb_pkg::SAMPLE_BITS-1:0] sample_value,
    input  logic [acrb_pkg::CH_W-1:0]           query_channel,
    output logic                                accepted,
    output logic                                read_valid,
    output logic signed [acrb_pkg::SAMPLE_BITS-1:0] read_sample,
    output logic [acrb_pkg::CH_W-1:0]           read_channel,
    output logic                                read_frame_end,
    output logic [acrb_pkg::RING_W-1:0]         free_frames,
    output logic [acrb_pkg::CNT_W-1:0]          dropped_frames,
    output logic [acrb_pkg::CNT_W-1:0]          captured_frames,
    output logic [acrb_pkg::CNT_W-1:0]          written_frames,
    output logic [acrb_pkg::PEAK_W-1:0]         peak_level
);

    import acrb_pkg::*;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
    endfunction

    // configuration
    logic [NCH_W-1:0]  num_channels_reg, num_channels_next;
    logic [RING_W-1:0] ring_frames_reg, ring_frames_next;
    logic              record_enable_reg, record_enable_next;

    // ring state
    logic [FRAME_W-1:0]      wfi_reg, wfi_next;
    logic [FRAME_W-1:0]      rfi_reg, rfi_next;
    logic [RING_W-1:0]       fill_reg, fill_next;
    logic [FRAME_W-1:0]      remaining_reg, remaining_next;
    logic                    admitted_reg, admitted_next;
    logic [FRAME_W-1:0]      pending_reg, pending_next;
    logic [CH_W-1:0]         wch_reg, wch_next;
    logic [CH_W-1:0]         rch_reg, rch_next;
    logic [MAX_CHANNELS-1:0] peak_valid_reg, peak_valid_next;
    logic [CNT_W-1:0]        dropped_reg, dropped_next;
    logic [CNT_W-1:0]        captured_reg, captured_next;
    logic [CNT_W-1:0]        written_reg, written_next;

    // latched request and pipeline
    logic [1:0]             req_reg;
    logic [FRAME_W-1:0]     frames_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [CH_W-1:0]        query_reg;
    logic [FRAME_W-1:0]     frame_mod_reg;
    logic [CH_W-1:0]        ch_sel_reg;
    logic [STORE_AW-1:0]    addr_reg;

    // result
    logic                   accepted_reg, res_accepted;
    logic                   read_valid_reg, res_read_valid;
    logic [SAMPLE_BITS-1:0] read_sample_reg, res_read_sample;
    logic [CH_W-1:0]        read_channel_reg, res_read_channel;
    logic                   read_frame_end_reg, res_read_frame_end;

    // derived geometry
    logic [NCH_W-1:0]  nch;
    logic [NCH_W-1:0]  nch_m1;
    logic [RING_W-1:0] cap;
    logic [RING_W-1:0] ring;
    logic [RING_W-1:0] free_now;

    // MOD / ADDR step
    logic [RING_W-1:0]       frame_sum;
    logic [RING_W-1:0]       frame_wrap;
    logic [CH_W-1:0]         ch_src;
    logic [NCH_W+FRAME_W-1:0] addr_prod;

    // conditions
    logic sample_live;
    logic sample_store;
    logic read_live;

    // peak
    logic [SAMPLE_BITS-1:0] neg_sample;
    logic [PEAK_W-1:0]      mag;
    logic [PEAK_W-1:0]      cur_peak;
    logic                   peak_we;
    logic                   peak_re;
    logic [CH_W-1:0]        peak_raddr;
    logic [PEAK_W-1:0]      peak_rdata;

    // store
    logic                   store_we;
    logic                   store_re;
    logic [SAMPLE_BITS-1:0] store_rdata;

    // update helpers
    logic [NCH_W-1:0]   wch_inc;
    logic [NCH_W-1:0]   rch_inc;
    logic [FRAME_W-1:0] rem_left;
    logic [FRAME_W-1:0] pend_new;
    logic [RING_W-1:0]  commit_sum;
    logic [RING_W-1:0]  rfi_inc;

    always_comb
    begin
        if (num_channels_reg == '0)
        begin
            nch = NCH_W'(1);
        end
        else if (num_channels_reg > NCH_W'(MAX_CHANNELS))
        begin
            nch = NCH_W'(MAX_CHANNELS);
        end
        else
        begin
            nch = num_channels_reg;
        end
        nch_m1 = nch - NCH_W'(1);
        cap    = RING_CAP[nch_m1[CH_W-1:0]];
        ring   = (ring_frames_reg > cap) ? cap : ring_frames_reg;
        if (ring == '0)
        begin
            ring = RING_W'(1);
        end
        free_now = (fill_reg > ring) ? '0 : ring - fill_reg;
    end

    assign sample_live  = (req_reg == REQ_SAMPLE) && record_enable_reg && (remaining_reg != '0);
    assign sample_store = sample_live && admitted_reg;
    assign read_live    = (req_reg == REQ_READ) && (fill_reg != '0);

    assign status.store_access = sample_store || read_live;

    // frame position reduced to the ring: both operands stay below twice the ring
    always_comb
    begin
        if (req_reg == REQ_SAMPLE)
        begin
            frame_sum = {1'b0, wfi_reg} + {1'b0, pending_reg};
            ch_src    = wch_reg;
        end
        else
        begin
            frame_sum = {1'b0, rfi_reg};
            ch_src    = rch_reg;
        end
        frame_wrap = (frame_sum >= ring) ? frame_sum - ring : frame_sum;
    end

    assign addr_prod = frame_mod_reg * nch;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg    <= req_type;
            frames_reg <= block_frames;
            sample_reg <= sample_value;
            query_reg  <= query_channel;
        end
        if (cmd.calc_mod)
        begin
            frame_mod_reg <= frame_wrap[FRAME_W-1:0];
            ch_sel_reg    <= ({1'b0, ch_src} < nch) ? ch_src : '0;
        end
        if (cmd.calc_addr)
        begin
            addr_reg <= addr_prod[STORE_AW-1:0] + STORE_AW'(ch_sel_reg);
        end
        if (cmd.update)
        begin
            accepted_reg       <= res_accepted;
            read_valid_reg     <= res_read_valid;
            read_sample_reg    <= res_read_sample;
            read_channel_reg   <= res_read_channel;
            read_frame_end_reg <= res_read_frame_end;
        end
    end

    // absolute value; the most negative code saturates
    always_comb
    begin
        neg_sample = '0 - sample_reg;
        if (!sample_reg[SAMPLE_BITS-1])
        begin
            mag = sample_reg[PEAK_W-1:0];
        end
        else if (sample_reg == SAMPLE_MOST_NEG)
        begin
            mag = PEAK_MAX;
        end
        else
        begin
            mag = neg_sample[PEAK_W-1:0];
        end
        cur_peak = peak_valid_reg[ch_sel_reg] ? peak_rdata : '0;
    end

    assign store_we   = cmd.mem_access && sample_store;
    assign store_re   = cmd.mem_access && read_live;
    assign peak_re    = (cmd.mem_access && sample_store) || cmd.query;
    assign peak_raddr = cmd.query ? query_reg : ch_sel_reg;
    assign peak_we    = cmd.update && sample_store && (mag > cur_peak);

    acrb_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (addr_reg),
        .wdata (sample_reg),
        .re    (store_re),
        .raddr (addr_reg),
        .rdata (store_rdata)
    );

    acrb_ram #(
        .WIDTH (PEAK_W),
        .DEPTH (MAX_CHANNELS)
    ) u_peak (
        .clk   (clk),
        .we    (peak_we),
        .waddr (ch_sel_reg),
        .wdata (mag),
        .re    (peak_re),
        .raddr (peak_raddr),
        .rdata (peak_rdata)
    );

    always_comb
    begin
        num_channels_next  = num_channels_reg;
        ring_frames_next   = ring_frames_reg;
        record_enable_next = record_enable_reg;
        wfi_next           = wfi_reg;
        rfi_next           = rfi_reg;
        fill_next          = fill_reg;
        remaining_next     = remaining_reg;
        admitted_next      = admitted_reg;
        pending_next       = pending_reg;
        wch_next           = wch_reg;
        rch_next           = rch_reg;
        peak_valid_next    = peak_valid_reg;
        dropped_next       = dropped_reg;
        captured_next      = captured_reg;
        written_next       = written_reg;

        res_accepted       = 1'b0;
        res_read_valid     = 1'b0;
        res_read_sample    = '0;
        res_read_channel   = '0;
        res_read_frame_end = 1'b0;

        wch_inc    = {1'b0, wch_reg} + NCH_W'(1);
        rch_inc    = {1'b0, ch_sel_reg} + NCH_W'(1);
        rem_left   = remaining_reg - FRAME_W'(1);
        pend_new   = admitted_reg ? pending_reg + FRAME_W'(1) : pending_reg;
        commit_sum = {1'b0, wfi_reg} + {1'b0, pend_new};
        rfi_inc    = {1'b0, rfi_reg} + RING_W'(1);

        if (peak_we)
        begin
            peak_valid_next[ch_sel_reg] = 1'b1;
        end

        if (cmd.update)
        begin
            case (req_reg)
                REQ_HEADER:
                begin
                    if (record_enable_reg && (frames_reg != '0))
                    begin
                        pending_next   = '0;
                        wch_next       = '0;
                        remaining_next = frames_reg;
                        if (free_now >= {1'b0, frames_reg})
                        begin
                            admitted_next = 1'b1;
                            res_accepted  = 1'b1;
                        end
                        else
                        begin
                            admitted_next = 1'b0;
                            dropped_next  = sat_add(dropped_reg, CNT_W'(frames_reg));
                        end
                    end
                end
                REQ_SAMPLE:
                begin
                    if (sample_live)
                    begin
                        res_accepted = admitted_reg;
                        if (wch_inc >= nch)
                        begin
                            wch_next       = '0;
                            remaining_next = rem_left;
                            pending_next   = pend_new;
                            if (rem_left == '0)
                            begin
                                // block complete: commit its frames
                                if (admitted_reg)
                                begin
                                    wfi_next = (commit_sum >= ring) ?
                                               FRAME_W'(commit_sum - ring) :
                                               commit_sum[FRAME_W-1:0];
                                    fill_next     = fill_reg + {1'b0, pend_new};
                                    captured_next = sat_add(captured_reg, CNT_W'(pend_new));
                                end
                                pending_next  = '0;
                                admitted_next = 1'b0;
                            end
                        end
                        else
                        begin
                            wch_next = wch_inc[CH_W-1:0];
                        end
                    end
                end
                REQ_READ:
                begin
                    if (read_live)
                    begin
                        res_read_valid   = 1'b1;
                        res_read_sample  = store_rdata;
                        res_read_channel = ch_sel_reg;
                        if (rch_inc >= nch)
                        begin
                            res_read_frame_end = 1'b1;
                            rch_next     = '0;
                            rfi_next     = (rfi_inc == ring) ? '0 : rfi_inc[FRAME_W-1:0];
                            fill_next    = fill_reg - RING_W'(1);
                            written_next = sat_add(written_reg, CNT_W'(1));
                        end
                        else
                        begin
                            rch_next = rch_inc[CH_W-1:0];
                        end
                    end
                end
                REQ_RESTART:
                begin
                    wfi_next        = '0;
                    rfi_next        = '0;
                    fill_next       = '0;
                    remaining_next  = '0;
                    admitted_next   = 1'b0;
                    pending_next    = '0;
                    wch_next        = '0;
                    rch_next        = '0;
                    peak_valid_next = '0;
                    dropped_next    = '0;
                    captured_next   = '0;
                    written_next    = '0;
                end
                default:
                begin
                end
            endcase
        end

        if (cfg_write)
        begin
            case (cfg_index)
                CFG_NUM_CHANNELS:
                begin
                    num_channels_next = cfg_data[NCH_W-1:0];
                end
                CFG_RING_FRAMES:
                begin
                    ring_frames_next = cfg_data[RING_W-1:0];
                end
                CFG_RECORD_ENABLE:
                begin
                    record_enable_next = cfg_data[0];
                end
                default:
                begin
                end
            endcase
            // geometry change empties the ring
            if ((cfg_index == CFG_NUM_CHANNELS) || (cfg_index == CFG_RING_FRAMES))
            begin
                wfi_next       = '0;
                rfi_next       = '0;
                fill_next      = '0;
                remaining_next = '0;
                admitted_next  = 1'b0;
                pending_next   = '0;
                wch_next       = '0;
                rch_next       = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_channels_reg  <= NCH_RESET;
            ring_frames_reg   <= RING_RESET;
            record_enable_reg <= 1'b0;
            wfi_reg           <= '0;
            rfi_reg           <= '0;
            fill_reg          <= '0;
            remaining_reg     <= '0;
            admitted_reg      <= 1'b0;
            pending_reg       <= '0;
            wch_reg           <= '0;
            rch_reg           <= '0;
            peak_valid_reg    <= '0;
            dropped_reg       <= '0;
            captured_reg      <= '0;
            written_reg       <= '0;
        end
        else
        begin
            num_channels_reg  <= num_channels_next;
            ring_frames_reg   <= ring_frames_next;
            record_enable_reg <= record_enable_next;
            wfi_reg           <= wfi_next;
            rfi_reg           <= rfi_next;
            fill_reg          <= fill_next;
            remaining_reg     <= remaining_next;
            admitted_reg      <= admitted_next;
            pending_reg       <= pending_next;
            wch_reg           <= wch_next;
            rch_reg           <= rch_next;
            peak_valid_reg    <= peak_valid_next;
            dropped_reg       <= dropped_next;
            captured_reg      <= captured_next;
            written_reg       <= written_next;
        end
    end

    assign accepted        = accepted_reg;
    assign read_valid      = read_valid_reg;
    assign read_sample     = $signed(read_sample_reg);
    assign read_channel    = read_channel_reg;
    assign read_frame_end  = read_frame_end_reg;
    assign free_frames     = free_now;
    assign dropped_frames  = dropped_reg;
    assign captured_frames = captured_reg;
    assign written_frames  = written_reg;
    // peak read of the query channel lands in the done cycle
    assign peak_level      = peak_valid_reg[query_reg] ? peak_rdata : '0;

endmodule

FILE: design/audio_capture_ring_buffer_core.sv
// ============================================================================
// audio_capture_ring_buffer_core
// Multichannel interleaved capture ring with per-channel peak hold.
// ============================================================================
//
// Channel   Handshake              Signals
// --------  ---------------------  -----------------------------------------
// request   start & !busy          req_type, block_frames, sample_value,
//                                  query_channel
// result    done (one cycle)       accepted, read_valid, read_sample,
//                                  read_channel, read_frame_end, free_frames,
//                                  dropped_frames, captured_frames,
//                                  written_frames, peak_level
// config    cfg_write              cfg_index, cfg_data
//
// A request that touches the sample store (stored sample or non-empty read)
// steps through ring reduce, address multiply, store access, update, peak
// query and done. Other requests skip the address and store steps.
// The single read port of the peak RAM sets the separate query step.
// Reset is asynchronous; the store needs no clearing pass.
// done is not held off by the receiver; the result stays valid for that cycle only.
// ============================================================================
module audio_capture_ring_buffer_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    output logic                                done,
    input  logic                                cfg_write,
    input  logic [acrb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [acrb_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [1:0]                          req_type,
    input  logic [acrb_pkg::FRAME_W-1:0]        block_frames,
    input  logic signed [acrb_pkg::SAMPLE_BITS-1:0] sample_value,
    input  logic [acrb_pkg::CH_W-1:0]           query_channel,
    output logic                                accepted,
    output logic                                read_valid,
    output logic signed [acrb_pkg::SAMPLE_BITS-1:0] read_sample,
    output logic [acrb_pkg::CH_W-1:0]           read_channel,
    output logic                                read_frame_end,
    output logic [acrb_pkg::RING_W-1:0]         free_frames,
    output logic [acrb_pkg::CNT_W-1:0]          dropped_frames,
    output logic [acrb_pkg::CNT_W-1:0]          captured_frames,
    output logic [acrb_pkg::CNT_W-1:0]          written_frames,
    output logic [acrb_pkg::PEAK_W-1:0]         peak_level
);

    import acrb_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    acrb_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    acrb_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .req_type        (req_type),
        .block_frames    (block_frames),
        .sample_value    (sample_value),
        .query_channel   (query_channel),
        .accepted        (accepted),
        .read_valid      (read_valid),
        .read_sample     (read_sample),
        .read_channel    (read_channel),
        .read_frame_end  (read_frame_end),
        .free_frames     (free_frames),
        .dropped_frames  (dropped_frames),
        .captured_frames (captured_frames),
        .written_frames  (written_frames),
        .peak_level      (peak_level)
    );

    assign done = cmd.done;

endmodule
